@@ hw/rtl/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the shell token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int KindBits = 6;
	localparam int FieldBits = 16;
	localparam int NumBits = 63;
	localparam int KwTotal = 17;
	localparam int KwMaxLen = 8;

	localparam logic [KindBits-1:0] K_LPAREN = 6'd17;
	localparam logic [KindBits-1:0] K_RPAREN = 6'd18;
	localparam logic [KindBits-1:0] K_LBRACE = 6'd19;
	localparam logic [KindBits-1:0] K_RBRACE = 6'd20;
	localparam logic [KindBits-1:0] K_MINUS = 6'd22;
	localparam logic [KindBits-1:0] K_PLUS = 6'd23;
	localparam logic [KindBits-1:0] K_COLON = 6'd24;
	localparam logic [KindBits-1:0] K_SEMI = 6'd25;
	localparam logic [KindBits-1:0] K_STAR = 6'd27;
	localparam logic [KindBits-1:0] K_DOLLAR = 6'd28;
	localparam logic [KindBits-1:0] K_SUBST = 6'd29;
	localparam logic [KindBits-1:0] K_AMP = 6'd30;
	localparam logic [KindBits-1:0] K_AND = 6'd31;
	localparam logic [KindBits-1:0] K_BANG = 6'd32;
	localparam logic [KindBits-1:0] K_BANG2 = 6'd33;
	localparam logic [KindBits-1:0] K_NE = 6'd34;
	localparam logic [KindBits-1:0] K_ASSIGN = 6'd35;
	localparam logic [KindBits-1:0] K_EQ = 6'd36;
	localparam logic [KindBits-1:0] K_DOT = 6'd45;
	localparam logic [KindBits-1:0] K_DOT2 = 6'd46;
	localparam logic [KindBits-1:0] K_PIPE = 6'd47;
	localparam logic [KindBits-1:0] K_OR = 6'd48;
	localparam logic [KindBits-1:0] K_IDENT = 6'd49;
	localparam logic [KindBits-1:0] K_STRING = 6'd50;
	localparam logic [KindBits-1:0] K_NUMBER = 6'd51;
	localparam logic [KindBits-1:0] K_NEWLINE = 6'd52;
	localparam logic [KindBits-1:0] K_ERROR = 6'd53;
	localparam logic [KindBits-1:0] K_EOF = 6'd54;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_CHAR = 2'd1;
	localparam logic [1:0] ERR_STRING = 2'd2;

	// One result beat.
	typedef struct packed {
		logic [KindBits-1:0]  kind;
		logic [FieldBits-1:0] start;
		logic [FieldBits-1:0] len;
		logic [NumBits-1:0]   value;
		logic [1:0]           err;
		logic                 last;
	} token_t;

	// Keyword character at a given offset; zero past its end.
	function automatic logic [7:0] kw_char(input int unsigned i, input logic [2:0] k);
		logic [63:0] t;
		int n;
		case (i)
			0: t = "do";
			1: t = "done";
			2: t = "case";
			3: t = "esac";
			4: t = "function";
			5: t = "select";
			6: t = "until";
			7: t = "if";
			8: t = "elif";
			9: t = "fi";
			10: t = "then";
			11: t = "while";
			12: t = "else";
			13: t = "for";
			14: t = "in";
			15: t = "time";
			16: t = "return";
			default: t = '0;
		endcase
		// Literals sit right-aligned, so the first character is the top-most nonzero byte.
		n = 0;
		for (int j = 0; j < KwMaxLen; j++) begin
			if (t[8*j +: 8] != 8'h00) n = j + 1;
		end
		if (32'(k) < 32'(n)) kw_char = t[8*(n-1-int'(k)) +: 8];
		else kw_char = 8'h00;
	endfunction

	function automatic logic [3:0] kw_len(input int unsigned i);
		case (i)
			0, 7, 9, 14: kw_len = 4'd2;
			13: kw_len = 4'd3;
			1, 2, 3, 8, 10, 12, 15: kw_len = 4'd4;
			6, 11: kw_len = 4'd5;
			5, 16: kw_len = 4'd6;
			4: kw_len = 4'd8;
			default: kw_len = 4'd0;
		endcase
	endfunction

endpackage

@@ hw/rtl/stl_front.sv @@
// ----------------------------------------------------------------------------
// stl_front
// Scanner: takes one byte a beat, tracks lexer state and forms up to two
// token beats for each byte, pushed together into the queue.
// ----------------------------------------------------------------------------
module stl_front #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_COUNT = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_char,
	input  logic                  q_room,
	output logic                  push,
	output logic [1:0]            push_n,
	output stl_pkg::token_t       tok0,
	output stl_pkg::token_t       tok1
);
	import stl_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_PEND, M_NUM, M_IDENT, M_STR, M_CMT, M_DRAIN
	} mode_t;

	localparam logic [POSITION_BITS-1:0] PosMax = '1;
	localparam logic [NumBits-1:0] NumMax = '1;
	// Largest accumulator for which acc*10+9 cannot overflow.
	localparam logic [NumBits-1:0] SafeMax = NumBits'((64'h7FFFFFFFFFFFFFFF - 64'd9) / 64'd10);

	mode_t                    mode_q;
	logic [7:0]               pend_q;
	logic [POSITION_BITS-1:0] pos_q, start_q, len_q;
	logic [NumBits-1:0]       acc_q;
	logic [KwTotal-1:0]       cand_q;

	mode_t                    mode_d;
	logic [7:0]               pend_d;
	logic [POSITION_BITS-1:0] pos_d, start_d, len_d;
	logic [NumBits-1:0]       acc_d;
	logic [KwTotal-1:0]       cand_d;
	logic                     eof;
	logic [1:0]               n;
	token_t                   t0, t1, tf;
	logic                     fresh_go, fresh_emit;
	logic [7:0]               c;
	logic [3:0]               d;
	logic [NumBits+3:0]       prod;

	assign c = in_char;
	assign in_ready = q_room;
	assign d = 4'(c - 8'h30);

	function automatic logic dec_digit(input logic [7:0] x);
		dec_digit = (x >= "0") && (x <= "9");
	endfunction
	function automatic logic name_char(input logic [7:0] x);
		name_char = (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
	endfunction
	function automatic token_t mk(input logic [KindBits-1:0] k,
		input logic [POSITION_BITS-1:0] s, input logic [POSITION_BITS-1:0] l,
		input logic [NumBits-1:0] v, input logic [1:0] e);
		mk.kind = k;
		mk.start = FieldBits'(s);
		mk.len = FieldBits'(l);
		mk.value = v;
		mk.err = e;
		mk.last = 1'b0;
	endfunction

	// Candidate filter for the character at offset k of the identifier.
	function automatic logic [KwTotal-1:0] filt(input logic [KwTotal-1:0] cin,
		input logic [POSITION_BITS-1:0] k, input logic [7:0] x);
		filt = cin;
		for (int i = 0; i < KwTotal; i++) begin
			if (i >= KEYWORD_COUNT || k >= POSITION_BITS'(KwMaxLen)) filt[i] = 1'b0;
			else if (kw_char(i, k[2:0]) != x) filt[i] = 1'b0;
		end
	endfunction

	always_comb begin
		logic [KindBits-1:0] ik;
		logic [KindBits-1:0] pk;
		logic                joined;
		mode_d = mode_q; pend_d = pend_q; start_d = start_q; len_d = len_q;
		acc_d = acc_q; cand_d = cand_q; eof = 1'b0;
		t0 = mk(K_EOF, '0, '0, '0, ERR_NONE); t1 = t0; tf = t0;
		n = 2'd0; fresh_go = 1'b0; fresh_emit = 1'b0;
		prod = {4'd0, acc_q} * (NumBits+4)'(10) + (NumBits+4)'(d);
		ik = K_IDENT;
		for (int i = KwTotal-1; i >= 0; i--) begin
			if (cand_q[i] && i < KEYWORD_COUNT &&
				len_q == POSITION_BITS'(kw_len(i))) ik = KindBits'(i);
		end
		joined = 1'b1;
		case (pend_q)
			"$": if (c == "(") pk = K_SUBST; else begin pk = K_DOLLAR; joined = 1'b0; end
			"&": if (c == "&") pk = K_AND; else begin pk = K_AMP; joined = 1'b0; end
			"=": if (c == "=") pk = K_EQ; else begin pk = K_ASSIGN; joined = 1'b0; end
			".": if (c == ".") pk = K_DOT2; else begin pk = K_DOT; joined = 1'b0; end
			"|": if (c == "|") pk = K_OR; else begin pk = K_PIPE; joined = 1'b0; end
			default: begin
				if (c == "!") pk = K_BANG2;
				else if (c == "=") pk = K_NE;
				else begin pk = K_BANG; joined = 1'b0; end
			end
		endcase

		case (mode_q)
			M_PEND: begin
				t0 = mk(pk, start_q, '0, '0, ERR_NONE); n = 2'd1;
				if (joined) mode_d = M_IDLE; else fresh_go = 1'b1;
			end
			M_NUM: begin
				if (dec_digit(c)) begin
					if (acc_q > SafeMax &&
						prod > {4'd0, NumMax}) acc_d = NumMax;
					else acc_d = NumBits'(prod);
				end else begin
					t0 = mk(K_NUMBER, start_q, '0, acc_q, ERR_NONE); n = 2'd1;
					fresh_go = 1'b1;
				end
			end
			M_IDENT: begin
				if (name_char(c) || dec_digit(c)) begin
					cand_d = filt(cand_q, len_q, c);
					if (len_q != PosMax) len_d = len_q + 1'b1;
				end else begin
					t0 = mk(ik, start_q, len_q, '0, ERR_NONE); n = 2'd1;
					fresh_go = 1'b1;
				end
			end
			M_STR: begin
				if (c == "\"") begin
					t0 = mk(K_STRING, start_q, len_q, '0, ERR_NONE); n = 2'd1;
					mode_d = M_IDLE;
				end else if (c == 8'h00) begin
					t0 = mk(K_ERROR, start_q, len_q, '0, ERR_STRING);
					t1 = mk(K_EOF, pos_q, '0, '0, ERR_NONE);
					n = 2'd2; eof = 1'b1;
				end else if (len_q != PosMax) len_d = len_q + 1'b1;
			end
			M_CMT: begin
				if (c == 8'h0A) mode_d = M_IDLE;
				else if (c == 8'h00) fresh_go = 1'b1;
			end
			M_DRAIN: if (c == 8'h00) fresh_go = 1'b1;
			default: fresh_go = 1'b1;
		endcase

		if (fresh_go) begin
			start_d = pos_q; len_d = '0; acc_d = '0; mode_d = M_IDLE;
			fresh_emit = 1'b1;
			case (c)
				8'h00: begin tf = mk(K_EOF, pos_q, '0, '0, ERR_NONE); eof = 1'b1; end
				"(": tf = mk(K_LPAREN, pos_q, '0, '0, ERR_NONE);
				")": tf = mk(K_RPAREN, pos_q, '0, '0, ERR_NONE);
				"{": tf = mk(K_LBRACE, pos_q, '0, '0, ERR_NONE);
				"}": tf = mk(K_RBRACE, pos_q, '0, '0, ERR_NONE);
				"-": tf = mk(K_MINUS, pos_q, '0, '0, ERR_NONE);
				"+": tf = mk(K_PLUS, pos_q, '0, '0, ERR_NONE);
				":": tf = mk(K_COLON, pos_q, '0, '0, ERR_NONE);
				";": tf = mk(K_SEMI, pos_q, '0, '0, ERR_NONE);
				"*": tf = mk(K_STAR, pos_q, '0, '0, ERR_NONE);
				8'h0A: tf = mk(K_NEWLINE, pos_q, '0, '0, ERR_NONE);
				" ", 8'h09, 8'h0D: fresh_emit = 1'b0;
				"$", "&", "=", ".", "|", "!": begin
					pend_d = c; mode_d = M_PEND; fresh_emit = 1'b0;
				end
				"#": begin mode_d = M_CMT; fresh_emit = 1'b0; end
				"\"": begin
					start_d = (pos_q != PosMax) ? pos_q + 1'b1 : PosMax;
					mode_d = M_STR; fresh_emit = 1'b0;
				end
				default: begin
					fresh_emit = 1'b0;
					if (dec_digit(c)) begin
						acc_d = NumBits'(d); mode_d = M_NUM;
					end else if (name_char(c)) begin
						cand_d = filt('1, '0, c);
						len_d = POSITION_BITS'(1); mode_d = M_IDENT;
					end else begin
						tf = mk(K_ERROR, pos_q, '0, '0, ERR_CHAR);
						fresh_emit = 1'b1; mode_d = M_DRAIN;
					end
				end
			endcase
			if (fresh_emit) begin
				if (n == 2'd0) t0 = tf; else t1 = tf;
				n = n + 2'd1;
			end
		end
		if (n == 2'd1) t0.last = 1'b1;
		if (n == 2'd2) t1.last = 1'b1;
		pos_d = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;
	end

	assign push = in_valid && in_ready && (n != 2'd0);
	assign push_n = n;
	assign tok0 = t0;
	assign tok1 = t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; pos_q <= '0; start_q <= '0;
			len_q <= '0; acc_q <= '0; cand_q <= '1;
		end else if (in_valid && in_ready) begin
			if (eof) begin
				mode_q <= M_IDLE; pend_q <= '0; pos_q <= '0; start_q <= '0;
				len_q <= '0; acc_q <= '0; cand_q <= '1;
			end else begin
				mode_q <= mode_d; pend_q <= pend_d; pos_q <= pos_d;
				start_q <= start_d; len_q <= len_d; acc_q <= acc_d; cand_q <= cand_d;
			end
		end
	end
endmodule

@@ hw/rtl/stl_queue.sv @@
// ----------------------------------------------------------------------------
// stl_queue
// Token queue: takes one or two beats at a time, gives one beat at a time.
// ----------------------------------------------------------------------------
module stl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [1:0]      push_n,
	input  stl_pkg::token_t tok0,
	input  stl_pkg::token_t tok1,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output stl_pkg::token_t out_tok
);
	import stl_pkg::*;

	localparam int Depth = 4;

	token_t     mem_q [Depth];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 3'd0;
	assign out_tok = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	// Room for two beats, counting one leaving this cycle.
	assign room = (cnt_q - {2'd0, pop}) <= 3'(Depth - 2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= tok0;
			if (push_n == 2'd2) mem_q[wr_q + 2'd1] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 2'd1;
			if (push) wr_q <= wr_q + push_n;
			cnt_q <= cnt_q + (push ? {1'b0, push_n} : 3'd0) - {2'd0, pop};
		end
	end
endmodule

@@ hw/rtl/shell_token_lexer.sv @@
// ----------------------------------------------------------------------------
// shell_token_lexer
// Byte-serial lexer for a small shell language.
// ----------------------------------------------------------------------------
// The lexer takes one source byte a beat, with byte 0 ending a source, and
// gives token beats with kind, start, length, number value and error code.
// It accepts a byte every cycle while the queue has room for two beats: the
// scanner classifies each byte and pushes up to two tokens into a four-entry
// queue, and the output side drains that queue one token a cycle while
// out_ready is high. A byte that ends a pending token and starts another
// gives two beats, so a long run of such bytes is limited to one token a
// cycle by the output port. last_of_run marks the final token of each byte.
// After the end byte the lexer starts a fresh source at offset 0.
module shell_token_lexer #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_COUNT = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [15:0] start_position,
	output logic [15:0] token_length,
	output logic [62:0] number_value,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	import stl_pkg::*;

	logic       room, push;
	logic [1:0] push_n;
	token_t     tok0, tok1, head;

	stl_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_COUNT(KEYWORD_COUNT)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_char(char_code),
		.q_room(room), .push, .push_n, .tok0, .tok1
	);

	stl_queue u_queue (
		.clk, .arst_n, .push, .push_n, .tok0, .tok1, .room,
		.out_valid, .out_ready, .out_tok(head)
	);

	assign token_kind = head.kind;
	assign start_position = head.start;
	assign token_length = head.len;
	assign number_value = head.value;
	assign error_code = head.err;
	assign last_of_run = head.last;
endmodule
